FILE: hw/rtl/tpcd_pkg.sv
// Shared constants for the touch pad calibrate/debounce block.
package tpcd_pkg;

	// Pad index width on the input stream and in events.
	localparam int PAD_W = 2;
	// Width of the pad count compare (covers NUM_PADS up to 31).
	localparam int CNT_W = 5;
	// Debounce streak counter, saturates at its maximum.
	localparam int STREAK_W = 4;
	localparam logic [STREAK_W-1:0] STREAK_MAX = 4'd15;
	// Threshold scale is unsigned Q2.6.
	localparam int SCALE_W = 8;
	localparam int SCALE_FRAC = 6;
	// Fixed widths of the stream fields.
	localparam int SAMPLE_W = 16;
	localparam int KEY_W = 8;

	// Configuration register indexes.
	localparam logic [1:0] REG_PADS_IN_USE     = 2'd0;
	localparam logic [1:0] REG_KEY_CODES       = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE_LIMIT  = 2'd2;
	localparam logic [1:0] REG_THRESHOLD_SCALE = 2'd3;

	// Register reset values.
	localparam logic [2:0]  PADS_IN_USE_RST     = 3'd4;
	localparam logic [31:0] KEY_CODES_RST       = 32'd134480385;
	localparam logic [3:0]  DEBOUNCE_LIMIT_RST  = 4'd5;
	localparam logic [7:0]  THRESHOLD_SCALE_RST = 8'd112;

endpackage

FILE: hw/rtl/tpcd_cal_div.sv
// Divide by a constant through multiplication with a rounded-up reciprocal.
module tpcd_cal_div #(
	parameter int DIVISOR = 10,
	parameter int WIDTH   = 32
) (
	input  logic [WIDTH-1:0] dividend,
	output logic [WIDTH-1:0] quotient
);

	// shift of WIDTH + ceil(log2 DIVISOR) keeps the quotient exact over the full dividend range
	localparam int SHIFT  = WIDTH + $clog2(DIVISOR);
	localparam int RCP_W  = WIDTH + 2;
	localparam int PROD_W = SHIFT + WIDTH;
	localparam longint unsigned RCP_FULL =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

	logic [PROD_W-1:0] prod;

	assign prod     = PROD_W'(dividend) * PROD_W'(RCP);
	assign quotient = prod[SHIFT +: WIDTH];

endmodule

FILE: hw/rtl/touch_pad_calibrate_debounce.sv
// Top level: capacitive touch pad calibration, thresholding and debounce.
//
// One charge-time sample word per pad comes in on the s_ stream, pads in cyclic
// index order; the last pad in use ends a round. The first CAL_ROUNDS rounds
// sum samples per pad; a pad's sample in the final round turns its sum into a
// threshold, floor(floor(sum/CAL_ROUNDS)*threshold_scale/64). After that, a
// sample above the threshold means touched, and a level that differs from the
// pressed state on more than debounce_limit consecutive samples flips the pad
// and sends one event word on the m_ stream. Rate: one sample word per clock;
// samples pass an input register, events an output register. The final-round
// divide by CAL_ROUNDS is a reciprocal multiply in the input stage; the scaled
// threshold is written in the next cycle, so a word for the same pad that
// directly follows its final calibration word waits for that write. Otherwise
// the input only stalls while an event word waits on a stalled m_ stream. The
// config port always accepts; write it only while the block is idle.
module touch_pad_calibrate_debounce #(
	parameter int NUM_PADS    = 4,
	parameter int CAL_ROUNDS  = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic [1:0]  s_tuser,   // [1:0] pad_index
	// event stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] event_key, [15:8] pressed_keys
	output logic [2:0]  m_tuser,   // [1:0] event_pad, [2] now_pressed
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SMP_W  = (SAMPLE_BITS < tpcd_pkg::SAMPLE_W) ? SAMPLE_BITS
	                                                           : tpcd_pkg::SAMPLE_W;
	// accumulator headroom well beyond CAL_ROUNDS samples per pad
	localparam int LVL_W  = SMP_W + 16;
	localparam int PROD_W = LVL_W + tpcd_pkg::SCALE_W;
	localparam int PIDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
	localparam int RL_W   = $clog2(CAL_ROUNDS + 1);
	localparam int CW     = tpcd_pkg::CNT_W;

	// ---------------- configuration registers ----------------
	logic [2:0]  pads_in_use_q;
	logic [31:0] key_codes_q;
	logic [3:0]  debounce_limit_q;
	logic [7:0]  threshold_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pads_in_use_q     <= tpcd_pkg::PADS_IN_USE_RST;
			key_codes_q       <= tpcd_pkg::KEY_CODES_RST;
			debounce_limit_q  <= tpcd_pkg::DEBOUNCE_LIMIT_RST;
			threshold_scale_q <= tpcd_pkg::THRESHOLD_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpcd_pkg::REG_PADS_IN_USE:     pads_in_use_q     <= cfg_data[2:0];
				tpcd_pkg::REG_KEY_CODES:       key_codes_q       <= cfg_data;
				tpcd_pkg::REG_DEBOUNCE_LIMIT:  debounce_limit_q  <= cfg_data[3:0];
				tpcd_pkg::REG_THRESHOLD_SCALE: threshold_scale_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                       valid_s1;
	logic [tpcd_pkg::PAD_W-1:0] pad_s1;
	logic [SMP_W-1:0]           smp_s1;
	logic                       s_fire;
	logic                       s1_fire;
	logic                       s1_adv;

	assign s_tready = !valid_s1 || s1_adv;
	assign s_fire   = s_tvalid && s_tready;
	assign s1_fire  = valid_s1 && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			pad_s1 <= s_tuser;
			smp_s1 <= s_tdata[SMP_W-1:0];
		end
	end

	// ---------------- per-pad state ----------------
	logic [LVL_W-1:0]              level_q   [NUM_PADS];
	logic [tpcd_pkg::STREAK_W-1:0] streak_q  [NUM_PADS];
	logic                          pressed_q [NUM_PADS];
	logic [RL_W-1:0]               rounds_left_q;
	logic [tpcd_pkg::KEY_W-1:0]    key_mask_q;

	// ---------------- calibration threshold ----------------
	logic [LVL_W-1:0]           div_quo;
	logic                       cal_load;
	logic                       cal_valid_s2;
	logic [tpcd_pkg::PAD_W-1:0] cal_pad_s2;
	logic [LVL_W-1:0]           cal_quo_s2;
	logic [PROD_W-1:0]          thr_prod;
	logic [LVL_W-1:0]           thr_val;
	logic                       hazard;

	// ---------------- single-pass evaluation ----------------
	logic [CW-1:0]                 eff_cnt;
	logic [CW-1:0]                 pad_ext;
	logic [PIDX_W-1:0]             pad_ix;
	logic                          in_use;
	logic                          last_pad;
	logic                          calib;
	logic                          final_rnd;
	logic [LVL_W-1:0]              lvl_rd;
	logic [LVL_W-1:0]              sum;
	logic                          touched;
	logic                          differs;
	logic [tpcd_pkg::STREAK_W-1:0] streak_inc;
	logic                          flip;
	logic                          emit;
	logic [tpcd_pkg::KEY_W-1:0]    key;
	logic [tpcd_pkg::KEY_W-1:0]    mask_nxt;

	always_comb begin
		// pads_in_use of zero acts as one, above NUM_PADS as NUM_PADS
		if (pads_in_use_q == 3'd0) begin
			eff_cnt = CW'(1);
		end else if (CW'(pads_in_use_q) > CW'(NUM_PADS)) begin
			eff_cnt = CW'(NUM_PADS);
		end else begin
			eff_cnt = CW'(pads_in_use_q);
		end
	end

	assign pad_ext   = CW'(pad_s1);
	assign pad_ix    = PIDX_W'(pad_s1);
	assign in_use    = pad_ext < eff_cnt;
	assign last_pad  = pad_ext == (eff_cnt - CW'(1));
	assign calib     = rounds_left_q != '0;
	assign final_rnd = rounds_left_q == RL_W'(1);

	assign lvl_rd     = level_q[pad_ix];
	assign sum        = lvl_rd + LVL_W'(smp_s1);
	assign touched    = LVL_W'(smp_s1) > lvl_rd;
	assign differs    = pressed_q[pad_ix] != touched;
	assign streak_inc = (streak_q[pad_ix] == tpcd_pkg::STREAK_MAX) ? tpcd_pkg::STREAK_MAX
	                                                               : streak_q[pad_ix] + 4'd1;
	assign flip       = streak_inc > debounce_limit_q;
	assign emit       = valid_s1 && in_use && !calib && differs && flip;
	assign key        = key_codes_q[{pad_s1, 3'b000} +: tpcd_pkg::KEY_W];
	assign mask_nxt   = touched ? (key_mask_q | key) : (key_mask_q & ~key);

	// pad whose threshold is still being written cannot be read this cycle
	assign hazard = cal_valid_s2 && (pad_s1 == cal_pad_s2);

	// hold on a threshold write to this pad, and when an event finds the output full
	assign s1_adv = !hazard && (!emit || !m_tvalid || m_tready);

	assign cal_load = s1_fire && in_use && final_rnd;

	// floor(sum / CAL_ROUNDS) for the final-round sample
	tpcd_cal_div #(
		.DIVISOR (CAL_ROUNDS),
		.WIDTH   (LVL_W)
	) u_div (
		.dividend (sum),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_valid_s2 <= 1'b0;
		end else begin
			cal_valid_s2 <= cal_load;
		end
	end

	always_ff @(posedge clk) begin
		if (cal_load) begin
			cal_pad_s2 <= pad_s1;
			cal_quo_s2 <= div_quo;
		end
	end

	// mean times Q2.6 scale
	assign thr_prod = PROD_W'(cal_quo_s2) * PROD_W'(threshold_scale_q);
	assign thr_val  = thr_prod[LVL_W+tpcd_pkg::SCALE_FRAC-1:tpcd_pkg::SCALE_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PADS; i++) begin
				level_q[i]   <= '0;
				streak_q[i]  <= '0;
				pressed_q[i] <= 1'b0;
			end
			rounds_left_q <= RL_W'(CAL_ROUNDS);
			key_mask_q    <= '0;
		end else begin
			if (cal_valid_s2) begin
				level_q[PIDX_W'(cal_pad_s2)] <= thr_val;
			end
			if (s1_fire && in_use) begin
				if (calib) begin
					if (!final_rnd) begin
						level_q[pad_ix] <= sum;
					end
					if (last_pad) begin
						rounds_left_q <= rounds_left_q - RL_W'(1);
					end
				end else if (!differs) begin
					streak_q[pad_ix] <= '0;
				end else if (!flip) begin
					streak_q[pad_ix] <= streak_inc;
				end else begin
					streak_q[pad_ix]  <= '0;
					pressed_q[pad_ix] <= touched;
					key_mask_q        <= mask_nxt;
				end
			end
		end
	end

	// ---------------- output register ----------------
	logic                       out_valid_q;
	logic [tpcd_pkg::PAD_W-1:0] out_pad_q;
	logic [tpcd_pkg::KEY_W-1:0] out_key_q;
	logic                       out_now_q;
	logic [tpcd_pkg::KEY_W-1:0] out_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			out_pad_q  <= pad_s1;
			out_key_q  <= key;
			out_now_q  <= touched;
			out_mask_q <= mask_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_mask_q, out_key_q};
	assign m_tuser  = {out_now_q, out_pad_q};

	// ---------------- assertions ----------------
	// a pad is never read while its threshold write is pending
	a_no_fire_on_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		hazard |-> !s1_fire)
		else $error("sample processed while its pad threshold is being written");

	// events only after calibration
	a_no_event_in_cal: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (rounds_left_q == '0))
		else $error("event raised during calibration");

	// a press event carries a mask that contains its own key
	a_press_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_now_q) |-> ((out_mask_q & out_key_q) == out_key_q))
		else $error("press event mask misses its key");

endmodule

FILE: dv/touch_pad_calibrate_debounce_test.sv
// Self-checking testbench for the touch pad calibrate/debounce block.
module touch_pad_calibrate_debounce_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PADS    = 4;
	localparam int CAL_ROUNDS  = 10;
	localparam int SAMPLE_BITS = 16;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	// Margin for the pipeline and the threshold write to settle.
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 10;
	// Watchdog limit, well above the slowest legal run.
	localparam int LIMIT_NS     = 5_000_000;
	localparam int PHASE_WORDS  = 220;

	// One sample word headed for the s_ stream.
	typedef struct {
		logic [tpcd_pkg::PAD_W-1:0]    pad;
		logic [tpcd_pkg::SAMPLE_W-1:0] value;
	} sample_word_t;

	// One event word as it should appear on the m_ stream.
	typedef struct {
		logic [tpcd_pkg::PAD_W-1:0] pad;
		logic [tpcd_pkg::KEY_W-1:0] key;
		logic                       pressed;
		logic [tpcd_pkg::KEY_W-1:0] keys;
	} touch_event_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata   = '0;   // [15:0] sample
	logic [1:0]          s_tuser   = '0;   // [1:0] pad_index
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [15:0]         m_tdata;          // [7:0] event_key, [15:8] pressed_keys
	logic [2:0]          m_tuser;          // [1:0] event_pad, [2] now_pressed
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = tpcd_pkg::REG_PADS_IN_USE;
	logic [31:0]         cfg_data  = '0;

	touch_pad_calibrate_debounce #(
		.NUM_PADS    (NUM_PADS),
		.CAL_ROUNDS  (CAL_ROUNDS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow registers, updated on each accepted config write.
	// ------------------------------------------------------------------
	logic [2:0]                   pads_cfg  = tpcd_pkg::PADS_IN_USE_RST;
	logic [31:0]                  keys_cfg  = tpcd_pkg::KEY_CODES_RST;
	logic [3:0]                   limit_cfg = tpcd_pkg::DEBOUNCE_LIMIT_RST;
	logic [tpcd_pkg::SCALE_W-1:0] scale_cfg = tpcd_pkg::THRESHOLD_SCALE_RST;

	// ------------------------------------------------------------------
	// Pad state as the block should hold it.
	// pad_level is the running sum during calibration, the threshold after.
	// ------------------------------------------------------------------
	logic [19:0]                   pad_level   [NUM_PADS];
	logic [tpcd_pkg::STREAK_W-1:0] pad_streak  [NUM_PADS];
	logic                          pad_pressed [NUM_PADS];
	logic [4:0]                    rounds_left = 5'(CAL_ROUNDS);
	logic [tpcd_pkg::KEY_W-1:0]    key_mask    = '0;

	initial begin
		for (int p = 0; p < NUM_PADS; p++) begin
			pad_level[p]   = '0;
			pad_streak[p]  = '0;
			pad_pressed[p] = 1'b0;
		end
	end

	sample_word_t samples_waiting[$];   // not yet on the bus
	touch_event_t events_due[$];        // predicted, not yet seen

	int unsigned queued_cnt     = 0;
	int unsigned accepted_cnt   = 0;
	int unsigned ignored_cnt    = 0;
	int unsigned events_checked = 0;
	int unsigned settings_cnt   = 0;
	int unsigned errors         = 0;

	// Pad count actually in force; 0 acts as 1, above NUM_PADS clamps.
	function automatic int unsigned pads_active();
		if (pads_cfg == 0)
			return 1;
		if (pads_cfg > NUM_PADS)
			return NUM_PADS;
		return pads_cfg;
	endfunction

	// Apply one accepted sample word to the pad state; queue any event it causes.
	task automatic update_pad_state(input logic [tpcd_pkg::PAD_W-1:0] pad,
					input logic [tpcd_pkg::SAMPLE_W-1:0] smp);
		int unsigned                count;
		logic [31:0]                scaled;
		logic                       touched;
		logic [tpcd_pkg::KEY_W-1:0] key;
		touch_event_t               ev;
		count = pads_active();
		if (pad >= count) begin
			ignored_cnt++;
			return;
		end
		if (rounds_left != 0) begin
			pad_level[pad] = pad_level[pad] + 20'(smp);
			// final round: the sum becomes floor(mean) * scale / 64
			if (rounds_left == 1) begin
				scaled = (32'(pad_level[pad]) / 32'(CAL_ROUNDS)) * 32'(scale_cfg);
				pad_level[pad] = 20'(scaled >> tpcd_pkg::SCALE_FRAC);
			end
			if (pad == count - 1)
				rounds_left--;
			return;
		end
		touched = 20'(smp) > pad_level[pad];
		if (pad_pressed[pad] == touched) begin
			pad_streak[pad] = '0;
			return;
		end
		if (pad_streak[pad] != tpcd_pkg::STREAK_MAX)
			pad_streak[pad]++;
		if (pad_streak[pad] <= limit_cfg)
			return;
		pad_streak[pad]  = '0;
		pad_pressed[pad] = touched;
		key = keys_cfg[8*pad +: 8];
		key_mask = touched ? (key_mask | key) : (key_mask & ~key);
		ev = '{pad: pad, key: key, pressed: touched, keys: key_mask};
		events_due.push_back(ev);
	endtask

	function automatic string show_event(touch_event_t ev);
		return $sformatf("pad %0d key %02h %s mask %02h", ev.pad, ev.key,
			ev.pressed ? "press" : "release", ev.keys);
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length separated by random gaps.
	// word_taken is set at the rising edge and consumed at the falling edge.
	// ------------------------------------------------------------------
	bit          word_taken = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_taken = 1'b1;
			accepted_cnt++;
			update_pad_state(s_tuser, s_tdata);
		end
	end

	always @(negedge clk) begin
		sample_word_t w;
		if (word_taken || !s_tvalid) begin
			word_taken = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (samples_waiting.size() != 0) begin
				w = samples_waiting.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= w.value;
				s_tuser  <= w.pad;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					// half the bursts run straight on, some pause long
					case ($urandom_range(0, 7))
						0, 1, 2, 3: gap_left = 0;
						4, 5:       gap_left = $urandom_range(1, 3);
						6:          gap_left = $urandom_range(4, 12);
						default:    gap_left = $urandom_range(20, 40);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: tready follows a pattern that cycles through four modes,
	// from always ready to long runs of stall.
	// ------------------------------------------------------------------
	logic [9:0] stall_tick = '0;

	always @(negedge clk) begin
		stall_tick <= stall_tick + 10'd1;
		case (stall_tick[9:8])
			2'd0:    m_tready <= 1'b1;
			2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
			2'd2:    m_tready <= (stall_tick[2:0] == 3'd0);
			default: m_tready <= (stall_tick[5:4] != 2'b11);
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: each event word against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		touch_event_t got;
		touch_event_t want;
		if (m_tvalid && m_tready) begin
			got = '{pad: m_tuser[1:0], key: m_tdata[7:0], pressed: m_tuser[2],
				keys: m_tdata[15:8]};
			if (events_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("event with none due: %s", show_event(got));
			end else begin
				want = events_due.pop_front();
				events_checked++;
				if (got.pad !== want.pad || got.key !== want.key ||
				    got.pressed !== want.pressed || got.keys !== want.keys) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("event mismatch: expected %s, got %s",
							show_event(want), show_event(got));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_sample(input logic [tpcd_pkg::PAD_W-1:0] pad,
				    input logic [tpcd_pkg::SAMPLE_W-1:0] value);
		sample_word_t w;
		w = '{pad: pad, value: value};
		samples_waiting.push_back(w);
		queued_cnt++;
	endtask

	// Everything accepted, nothing due, and the pipeline given time to settle.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (accepted_cnt != queued_cnt || events_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Config write; only called while the block is quiet.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			tpcd_pkg::REG_PADS_IN_USE:     pads_cfg  = value[2:0];
			tpcd_pkg::REG_KEY_CODES:       keys_cfg  = value;
			tpcd_pkg::REG_DEBOUNCE_LIMIT:  limit_cfg = value[3:0];
			tpcd_pkg::REG_THRESHOLD_SCALE: scale_cfg = value[tpcd_pkg::SCALE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sample on one side of the pad's threshold, now and then right at it.
	function automatic logic [tpcd_pkg::SAMPLE_W-1:0] pick_sample(input int unsigned pad,
								     input bit touch);
		logic [19:0] thr;
		thr = pad_level[pad];
		if (touch) begin
			if (thr >= 20'hFFFF)
				return 16'hFFFF;
			if ($urandom_range(0, 7) == 0)
				return 16'(thr + 20'd1);
			return 16'($urandom_range(32'hFFFF, 32'(thr) + 32'd1));
		end
		if (thr > 20'hFFFF)
			return 16'($urandom_range(32'hFFFF, 0));
		if ($urandom_range(0, 7) == 0)
			return 16'(thr);
		return 16'($urandom_range(32'(thr), 0));
	endfunction

	// Per-pad intended level and how many more samples it holds.
	bit          gen_touch [NUM_PADS];
	int unsigned gen_run   [NUM_PADS];

	task automatic push_pad_traffic(input int unsigned n, input int unsigned run_max);
		int unsigned done_cnt;
		int unsigned cyc;
		int unsigned pad;
		int unsigned count;
		count    = pads_active();
		done_cnt = 0;
		cyc      = 0;
		while (done_cnt < n) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: any pad, any value, breaks the round order
				pad = $urandom_range(0, NUM_PADS - 1);
				queue_sample(tpcd_pkg::PAD_W'(pad), 16'($urandom_range(32'hFFFF, 0)));
				if (pad < count)
					done_cnt++;
			end else begin
				pad = cyc;
				cyc = (cyc + 1) % count;
				if (gen_run[pad] == 0) begin
					gen_touch[pad] = ~gen_touch[pad];
					gen_run[pad]   = $urandom_range(0, run_max);
				end else begin
					gen_run[pad]--;
				end
				queue_sample(tpcd_pkg::PAD_W'(pad), pick_sample(pad, gen_touch[pad]));
				done_cnt++;
			end
		end
	endtask

	// One register setting, traffic in two halves with a full drain between.
	task automatic run_setting(input logic [2:0] pads, input logic [31:0] keys,
				   input logic [3:0] limit, input int unsigned n);
		int unsigned lim;
		write_reg(tpcd_pkg::REG_PADS_IN_USE, {29'd0, pads});
		write_reg(tpcd_pkg::REG_KEY_CODES, keys);
		write_reg(tpcd_pkg::REG_DEBOUNCE_LIMIT, {28'd0, limit});
		settings_cnt++;
		// runs a bit longer than the limit so some flip and some fall short
		lim = (limit > 14) ? 14 : limit;
		push_pad_traffic(n / 2, lim + 3);
		wait_quiet();
		push_pad_traffic(n - n / 2, lim + 3);
		wait_quiet();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		for (int p = 0; p < NUM_PADS; p++) begin
			gen_touch[p] = 1'b0;
			gen_run[p]   = 0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Calibration, first nine rounds with all pads. Pad 1 sees a full-scale
		// sample, pad 0 a zero; pads 2 and 3 stay small since they keep raw sums.
		write_reg(tpcd_pkg::REG_PADS_IN_USE, 32'd4);
		for (int r = 0; r < CAL_ROUNDS - 1; r++) begin
			queue_sample(2'd0, (r == 2) ? 16'd0 : 16'($urandom_range(3000, 200)));
			queue_sample(2'd1, (r == 4) ? 16'hFFFF : 16'($urandom_range(4000, 500)));
			queue_sample(2'd2, 16'($urandom_range(900, 0)));
			queue_sample(2'd3, 16'($urandom_range(900, 0)));
		end
		wait_quiet();

		// Final round: pad 0 with a zero scale (threshold 0), pad 1 with the
		// largest scale, and pad 1 ends the round so pads 2 and 3 are skipped.
		write_reg(tpcd_pkg::REG_THRESHOLD_SCALE, 32'd0);
		queue_sample(2'd0, 16'($urandom_range(3000, 200)));
		wait_quiet();
		write_reg(tpcd_pkg::REG_THRESHOLD_SCALE, 32'd255);
		write_reg(tpcd_pkg::REG_PADS_IN_USE, 32'd2);
		queue_sample(2'd1, 16'($urandom_range(4000, 500)));
		wait_quiet();

		// Directed: single-sample debounce, extremes and threshold boundaries.
		write_reg(tpcd_pkg::REG_PADS_IN_USE, 32'd4);
		write_reg(tpcd_pkg::REG_DEBOUNCE_LIMIT, 32'd0);
		queue_sample(2'd0, 16'hFFFF);
		queue_sample(2'd1, 16'(pad_level[1] + 20'd1));
		queue_sample(2'd1, 16'(pad_level[1]));
		queue_sample(2'd2, 16'd0);
		queue_sample(2'd2, 16'hFFFF);
		queue_sample(2'd3, 16'hFFFF);
		queue_sample(2'd3, 16'd0);
		queue_sample(2'd0, 16'd0);
		queue_sample(2'd0, 16'd1);
		queue_sample(2'd1, 16'hFFFF);
		queue_sample(2'd2, 16'd0);
		queue_sample(2'd1, 16'd0);
		queue_sample(2'd0, 16'd0);
		wait_quiet();
		// only pad 0 in use: the rest are dropped
		write_reg(tpcd_pkg::REG_PADS_IN_USE, 32'd1);
		queue_sample(2'd3, 16'hFFFF);
		queue_sample(2'd2, 16'hFFFF);
		queue_sample(2'd1, 16'hFFFF);
		queue_sample(2'd0, 16'hFFFF);
		wait_quiet();

		// Random settings, pad count 0 and out-of-range counts among them.
		run_setting(3'd4, $urandom, 4'd0, PHASE_WORDS);
		run_setting(3'd3, 32'hFFFF_FFFF, 4'd3, PHASE_WORDS);
		run_setting(3'd1, $urandom, 4'd14, PHASE_WORDS);
		run_setting(3'd0, $urandom, 4'd1, PHASE_WORDS);
		run_setting(3'd7, 32'h0000_0000, 4'd2, PHASE_WORDS);
		// limit 15 can never be exceeded by the saturating streak
		run_setting(3'd2, $urandom, 4'd15, 100);
		run_setting(3'd5, $urandom, 4'd5, PHASE_WORDS);
		run_setting(3'd4, 32'h0301_0601, 4'd4, PHASE_WORDS);

		wait_quiet();
		if (events_due.size() != 0) begin
			$display("%0d events never arrived", events_due.size());
			errors += events_due.size();
		end

		$display("%0d sample words (%0d dropped as unused pads), %0d events checked",
			accepted_cnt, ignored_cnt, events_checked);
		$display("calibration with scales 0 and 255, %0d register settings, %0d errors",
			settings_cnt, errors);
		if (errors == 0) begin
			$display("touch_pad_calibrate_debounce_test: clean");
		end else begin
			$display("touch_pad_calibrate_debounce_test: errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(LIMIT_NS);
		$display("timeout: %0d of %0d words taken, %0d events due",
			accepted_cnt, queued_cnt, events_due.size());
		$display("touch_pad_calibrate_debounce_test: errors");
		$finish;
	end

endmodule
